// ===== rtl/mpq_pkg.sv =====
// shared types and constants for the unsorted-array min priority queue
// no dependencies; used by every module of the block
package mpq_pkg;

   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int LEVEL_W  = 7;
   localparam int CAP_W    = 7;

   localparam logic [ACTION_W-1:0] ACT_INSERT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEL_MIN  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK_OLD = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_PEEK_NEW = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LEVEL_W-1:0]  fill_level;
   } rsp_info_type;

endpackage

// ===== rtl/mpq_store.sv =====
// entry memory: one write port, one read port, registered read data
// depends on mpq_pkg for default sizes
module mpq_store #(
   parameter int DEPTH       = mpq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEFAULT,
   localparam int ADDR_W     = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mpq_out.sv =====
// result output register between the sequencer and the rsp channel
// depends on mpq_pkg for the status struct
module mpq_out #(
   parameter int VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic signed [VALUE_WIDTH-1:0]       load_value,
   input  mpq_pkg::rsp_info_type               load_info,
   output logic                                ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]       rsp_result_value,
   output logic [mpq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [mpq_pkg::LEVEL_W-1:0]         rsp_fill_level
);

   logic                           valid_ff;
   logic                           valid_in;
   logic signed [VALUE_WIDTH-1:0]  value_ff;
   mpq_pkg::rsp_info_type          info_ff;

   // free when empty or when the held transaction leaves this cycle
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= load_value;
         info_ff  <= load_info;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_value = value_ff;
   assign rsp_status       = info_ff.status;
   assign rsp_fill_level   = info_ff.fill_level;

endmodule

// ===== rtl/mpq_ctrl.sv =====
// sequencer: decodes actions, scans the entry memory for the minimum and
// closes the gap by moving later entries down; depends on mpq_pkg
module mpq_ctrl #(
   parameter int DEPTH       = mpq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEFAULT,
   localparam int ADDR_W     = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mpq_pkg::ACTION_W-1:0]      req_action,
   input  logic signed [VALUE_WIDTH-1:0]     req_insert_value,
   input  logic                              csr_wr_en,
   input  logic [mpq_pkg::CAP_W-1:0]         csr_wr_data,
   output logic                              mem_we,
   output logic [ADDR_W-1:0]                 mem_waddr,
   output logic [VALUE_WIDTH-1:0]            mem_wdata,
   output logic                              mem_re,
   output logic [ADDR_W-1:0]                 mem_raddr,
   input  logic [VALUE_WIDTH-1:0]            mem_rdata,
   input  logic                              out_ready,
   output logic                              out_load,
   output logic signed [VALUE_WIDTH-1:0]     out_value,
   output mpq_pkg::rsp_info_type             out_info
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > mpq_pkg::CAP_W) ? CNT_W : mpq_pkg::CAP_W) + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_PEEK  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [mpq_pkg::ACTION_W-1:0]   act_ff, act_in;
   logic [VALUE_WIDTH-1:0]         val_ff, val_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [mpq_pkg::CAP_W-1:0]      cap_ff, cap_in;
   logic [CNT_W-1:0]               rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]               data_idx_ff, data_idx_in;
   logic [CNT_W-1:0]               wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]               best_idx_ff, best_idx_in;
   logic [VALUE_WIDTH-1:0]         best_val_ff, best_val_in;
   logic [VALUE_WIDTH-1:0]         res_val_ff, res_val_in;
   logic [mpq_pkg::STATUS_W-1:0]   res_stat_ff, res_stat_in;

   logic [CMP_W-1:0]               fill_wide, cap_wide, depth_wide;
   logic [CMP_W-1:0]               data_idx_wide, best_nx_wide, wr_idx_wide;
   logic                           is_full, is_empty, take_new, last_data;
   logic [VALUE_WIDTH-1:0]         best_val_nx;
   logic [CNT_W-1:0]               best_idx_nx;
   logic [CNT_W-1:0]               best_plus1, wr_plus2, fill_minus1;

   assign fill_wide     = CMP_W'(fill_ff);
   assign cap_wide      = CMP_W'(cap_ff);
   assign depth_wide    = CMP_W'(DEPTH);
   assign data_idx_wide = CMP_W'(data_idx_ff);
   assign wr_idx_wide   = CMP_W'(wr_idx_ff);

   // a capacity above the built depth acts as the depth
   assign is_full  = (fill_wide >= cap_wide) || (fill_wide >= depth_wide);
   assign is_empty = (fill_ff == '0);

   // strict compare keeps the earliest entry on ties
   assign take_new    = (data_idx_ff == '0) || ($signed(mem_rdata) < $signed(best_val_ff));
   assign best_val_nx = take_new ? mem_rdata : best_val_ff;
   assign best_idx_nx = take_new ? data_idx_ff : best_idx_ff;
   assign best_nx_wide = CMP_W'(best_idx_nx);
   assign last_data   = (data_idx_wide + CMP_W'(1)) == fill_wide;

   assign best_plus1  = best_idx_nx + CNT_W'(1);
   assign wr_plus2    = wr_idx_ff + CNT_W'(2);
   assign fill_minus1 = fill_ff - CNT_W'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign cap_in    = csr_wr_en ? csr_wr_data : cap_ff;

   // writes during the shift trail the reads by two places, so the single
   // read port never sees a stale entry
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      val_in      = val_ff;
      fill_in     = fill_ff;
      rd_idx_in   = rd_idx_ff;
      data_idx_in = data_idx_ff;
      wr_idx_in   = wr_idx_ff;
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      res_val_in  = res_val_ff;
      res_stat_in = res_stat_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = val_ff;
      mem_re      = 1'b0;
      mem_raddr   = '0;
      out_load    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               val_in   = req_insert_value;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_val_in  = '0;
            res_stat_in = mpq_pkg::ST_OK;
            if (act_ff == mpq_pkg::ACT_INSERT) begin
               if (is_full) begin
                  res_stat_in = mpq_pkg::ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = fill_ff[ADDR_W-1:0];
                  fill_in   = fill_ff + CNT_W'(1);
               end
               state_in = S_DONE;
            end else if (is_empty) begin
               res_stat_in = mpq_pkg::ST_EMPTY;
               state_in    = S_DONE;
            end else if (act_ff == mpq_pkg::ACT_DEL_MIN) begin
               mem_re      = 1'b1;
               mem_raddr   = '0;
               rd_idx_in   = CNT_W'(1);
               data_idx_in = '0;
               state_in    = S_SCAN;
            end else if (act_ff == mpq_pkg::ACT_PEEK_OLD) begin
               mem_re    = 1'b1;
               mem_raddr = '0;
               state_in  = S_PEEK;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = fill_minus1[ADDR_W-1:0];
               state_in  = S_PEEK;
            end
         end
         S_PEEK: begin
            res_val_in = mem_rdata;
            state_in   = S_DONE;
         end
         S_SCAN: begin
            best_val_in = best_val_nx;
            best_idx_in = best_idx_nx;
            data_idx_in = data_idx_ff + CNT_W'(1);
            if (rd_idx_ff < fill_ff) begin
               mem_re    = 1'b1;
               mem_raddr = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (last_data) begin
               res_val_in = best_val_nx;
               if ((best_nx_wide + CMP_W'(1)) < fill_wide) begin
                  mem_re    = 1'b1;
                  mem_raddr = best_plus1[ADDR_W-1:0];
                  wr_idx_in = best_idx_nx;
                  state_in  = S_SHIFT;
               end else begin
                  fill_in  = fill_minus1;
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx_ff[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            wr_idx_in = wr_idx_ff + CNT_W'(1);
            if ((wr_idx_wide + CMP_W'(2)) < fill_wide) begin
               mem_re    = 1'b1;
               mem_raddr = wr_plus2[ADDR_W-1:0];
            end else begin
               fill_in  = fill_minus1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_value           = res_val_ff;
   assign out_info.status     = res_stat_ff;
   assign out_info.fill_level = fill_wide[mpq_pkg::LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         cap_ff   <= mpq_pkg::CAP_RESET;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      val_ff      <= val_in;
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= data_idx_in;
      wr_idx_ff   <= wr_idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      res_val_ff  <= res_val_in;
      res_stat_ff <= res_stat_in;
   end

endmodule

// ===== rtl/min_priority_queue_array_core.sv =====
// Min priority queue kept as an unsorted array in arrival order.
// req channel: req_action (insert, delete minimum, peek oldest, peek newest)
// and req_insert_value, taken when req_valid is high and req_stall low.
// rsp channel: one transaction per request with rsp_result_value, rsp_status
// (ok, full, empty) and rsp_fill_level, taken when rsp_valid and !rsp_stall.
// csr_wr_en / csr_wr_data set the capacity in use; write it only while idle.
// One request is worked at a time; the entries sit in a single-port-read
// memory. An insert, or any request that reports full or empty, is settled
// at dispatch; a peek of the oldest or newest entry reads that one entry;
// a delete minimum scans every entry with one memory read per cycle and
// then, if later entries follow the minimum, moves them down with one read
// plus one write per cycle.
// The next request can be taken in the cycle after the result loads.
// A new request is taken while an earlier result still waits on rsp_stall;
// its result then waits until the output register frees up.
// Reset (synchronous) empties the queue and sets the capacity to 64; the
// memory contents are not cleared, so no clearing pass is needed.
module min_priority_queue_array_core #(
   parameter int DEPTH       = mpq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mpq_pkg::ACTION_W-1:0]      req_action,
   input  logic signed [VALUE_WIDTH-1:0]     req_insert_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]     rsp_result_value,
   output logic [mpq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mpq_pkg::LEVEL_W-1:0]       rsp_fill_level,
   input  logic                              csr_wr_en,
   input  logic [mpq_pkg::CAP_W-1:0]         csr_wr_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic                          mem_we, mem_re;
   logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
   logic [VALUE_WIDTH-1:0]        mem_wdata, mem_rdata;
   logic                          out_ready, out_load;
   logic signed [VALUE_WIDTH-1:0] out_value;
   mpq_pkg::rsp_info_type         out_info;

   mpq_store #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   mpq_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_insert_value (req_insert_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_re           (mem_re),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata),
      .out_ready        (out_ready),
      .out_load         (out_load),
      .out_value        (out_value),
      .out_info         (out_info)
   );

   mpq_out #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (out_load),
      .load_value       (out_value),
      .load_info        (out_info),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_fill_level   (rsp_fill_level)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for min_priority_queue_array_core: directed and random request streams
// checked against an in-bench queue predictor; depends on rtl/mpq_pkg.sv and the core
module tb;

   localparam int DEPTH       = mpq_pkg::DEPTH_DEFAULT;
   localparam int VALUE_W     = mpq_pkg::VALUE_WIDTH_DEFAULT;
   localparam int ACTION_W    = mpq_pkg::ACTION_W;
   localparam int STATUS_W    = mpq_pkg::STATUS_W;
   localparam int LEVEL_W     = mpq_pkg::LEVEL_W;
   localparam int CAP_W       = mpq_pkg::CAP_W;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [CAP_W-1:0] CAP_TOP = '1;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [STATUS_W-1:0]       status;
      logic [LEVEL_W-1:0]        level;
   } queue_outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [ACTION_W-1:0]        req_action = mpq_pkg::ACT_INSERT;
   logic signed [VALUE_W-1:0]  req_insert_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_result_value;
   logic [STATUS_W-1:0]        rsp_status;
   logic [LEVEL_W-1:0]         rsp_fill_level;
   logic                       csr_wr_en = 1'b0;
   logic [CAP_W-1:0]           csr_wr_data = '0;

   // predictor state
   logic signed [VALUE_W-1:0]  model_entries [DEPTH];
   int                         model_fill = 0;
   logic [CAP_W-1:0]           model_capacity = mpq_pkg::CAP_RESET;
   queue_outcome_type          predicted_outcomes [$];
   queue_outcome_type          rsp_want;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int error_count = 0;
   int cycle_count = 0;

   min_priority_queue_array_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_insert_value (req_insert_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_fill_level   (rsp_fill_level),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic queue_outcome_type apply_queue_action(
         input logic [ACTION_W-1:0] action,
         input logic signed [VALUE_W-1:0] value);
      queue_outcome_type res;
      int limit;
      int best;
      res.value  = '0;
      res.status = mpq_pkg::ST_OK;
      limit = (model_capacity > DEPTH) ? DEPTH : int'(model_capacity);
      if (action == mpq_pkg::ACT_INSERT) begin
         if (model_fill >= limit) begin
            res.status = mpq_pkg::ST_FULL;
         end else begin
            model_entries[model_fill] = value;
            model_fill++;
         end
      end else if (model_fill == 0) begin
         res.status = mpq_pkg::ST_EMPTY;
      end else if (action == mpq_pkg::ACT_DEL_MIN) begin
         // strict less keeps the earliest of equal minima
         best = 0;
         for (int i = 1; i < model_fill; i++)
            if (model_entries[i] < model_entries[best]) best = i;
         res.value = model_entries[best];
         for (int i = best; i + 1 < model_fill; i++)
            model_entries[i] = model_entries[i + 1];
         model_fill--;
      end else if (action == mpq_pkg::ACT_PEEK_OLD) begin
         res.value = model_entries[0];
      end else begin
         res.value = model_entries[model_fill - 1];
      end
      res.level = LEVEL_W'(model_fill);
      return res;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return $urandom_range(0, 1) ? '0 : '1;
         3: return $signed($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(input int insert_pct);
      if ($urandom_range(0, 99) < insert_pct) return mpq_pkg::ACT_INSERT;
      case ($urandom_range(0, 3))
         0, 1: return mpq_pkg::ACT_DEL_MIN;
         2: return mpq_pkg::ACT_PEEK_OLD;
         default: return mpq_pkg::ACT_PEEK_NEW;
      endcase
   endfunction

   // called at a falling edge; leaves req_valid high on return
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic signed [VALUE_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid        <= 1'b0;
         req_action       <= ACTION_W'($urandom);
         req_insert_value <= $urandom;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_insert_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_outcomes.push_back(apply_queue_action(action, value));
      @(negedge clock);
   endtask

   task automatic wait_for_outcomes();
      req_valid        <= 1'b0;
      req_action       <= ACTION_W'($urandom);
      req_insert_value <= $urandom;
      @(negedge clock);
      while (predicted_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // only while idle: callers drain first
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CAP_W'($urandom);
      model_capacity = cap;
      @(negedge clock);
   endtask

   task automatic test_empty_and_extremes();
      send_request(mpq_pkg::ACT_PEEK_OLD, $urandom);
      send_request(mpq_pkg::ACT_PEEK_NEW, $urandom);
      send_request(mpq_pkg::ACT_DEL_MIN, $urandom);
      send_request(mpq_pkg::ACT_INSERT, VAL_MAX);
      send_request(mpq_pkg::ACT_INSERT, VAL_MIN);
      send_request(mpq_pkg::ACT_INSERT, '0);
      send_request(mpq_pkg::ACT_INSERT, '1);
      send_request(mpq_pkg::ACT_PEEK_OLD, $urandom);
      send_request(mpq_pkg::ACT_PEEK_NEW, $urandom);
      repeat (4) send_request(mpq_pkg::ACT_DEL_MIN, $urandom);
      wait_for_outcomes();
   endtask

   task automatic test_equal_minima();
      // the earlier of two equal minima leaves, so the newest stays the later copy
      send_request(mpq_pkg::ACT_INSERT, 5);
      send_request(mpq_pkg::ACT_INSERT, -1);
      send_request(mpq_pkg::ACT_INSERT, 7);
      send_request(mpq_pkg::ACT_INSERT, -1);
      send_request(mpq_pkg::ACT_DEL_MIN, $urandom);
      send_request(mpq_pkg::ACT_PEEK_NEW, $urandom);
      repeat (3) send_request(mpq_pkg::ACT_DEL_MIN, $urandom);
      wait_for_outcomes();
   endtask

   task automatic test_capacity_limits();
      write_capacity('0);
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      wait_for_outcomes();
      write_capacity(CAP_W'(1));
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      wait_for_outcomes();
      write_capacity(mpq_pkg::CAP_RESET);
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      wait_for_outcomes();
      // capacity below the fill level keeps the entries
      write_capacity(CAP_W'(2));
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      send_request(mpq_pkg::ACT_DEL_MIN, $urandom);
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      send_request(mpq_pkg::ACT_DEL_MIN, $urandom);
      send_request(mpq_pkg::ACT_INSERT, $urandom);
      wait_for_outcomes();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_seq++;
      repeat (30) send_request(pick_action(60), pick_value());
      wait_for_outcomes();
   endtask

   task automatic run_random_phase(input int items, input int first_insert_pct,
                                   input logic [CAP_W-1:0] cap);
      int insert_pct;
      write_capacity(cap);
      insert_pct = first_insert_pct;
      for (int n = 0; n < items; n++) begin
         if (n != 0 && n % 80 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 5;
               1: insert_pct = 50;
               default: insert_pct = 95;
            endcase
         end
         if (n != 0 && n % 100 == 0) begin
            // sender pauses until every transaction is back
            wait_for_outcomes();
            if ($urandom_range(0, 3) == 0) write_capacity(CAP_W'($urandom_range(1, 127)));
         end
         send_request(pick_action(insert_pct), pick_value());
      end
      wait_for_outcomes();
   endtask

   // receiver: random stalls, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none, %s %0d status %0d fill %0d",
                     $time, "actual value", rsp_result_value, rsp_status, rsp_fill_level);
         end else begin
            rsp_want = predicted_outcomes.pop_front();
            compare_field("result_value", rsp_want.value, rsp_result_value);
            compare_field("status", rsp_want.status, rsp_status);
            compare_field("fill_level", rsp_want.level, rsp_fill_level);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL min_priority_queue_array_core");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_equal_minima();
      test_capacity_limits();
      test_output_backpressure();
      send_idle_pct = 6;
      rsp_stall_pct = 53;
      run_random_phase(380, 95, CAP_TOP);
      send_idle_pct = 53;
      rsp_stall_pct = 6;
      run_random_phase(380, 50, CAP_W'($urandom_range(1, 8)));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_phase(380, 95, mpq_pkg::CAP_RESET);
      repeat (150) @(posedge clock);
      if (error_count == 0 && predicted_outcomes.size() == 0) begin
         $display("PASS min_priority_queue_array_core");
      end else begin
         $display("FAIL min_priority_queue_array_core");
      end
      $finish;
   end

endmodule
